/* sv/index_linked_list_engine_defines.svh */
// Assertion macros for the index linked list engine.
// Used by the top level; expects signals clk and rst in scope.
`ifndef INDEX_LINKED_LIST_ENGINE_DEFINES_SVH
`define INDEX_LINKED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define ILLE_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ILLE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ille_pkg.sv */
// Shared types and constants for the index linked list engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package ille_pkg;

  localparam int CAPACITY = 16;
  localparam int NSLOTS   = CAPACITY + 1;
  localparam int IDX_W    = $clog2(NSLOTS);
  localparam int VAL_W    = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [IDX_W-1:0] cnt_t;
  typedef logic [VAL_W-1:0] val_t;

  typedef enum logic [1:0] {
    CMD_SHOW       = 2'd0,
    CMD_INS_BEFORE = 2'd1,
    CMD_INS_AFTER  = 2'd2,
    CMD_DELETE     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FIND_RD,
    S_FIND_CMP,
    S_LINK,
    S_SHOW_RD,
    S_SHOW_EMIT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] new_value;
    logic signed [31:0] anchor_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic               last;
  } out_t;

  // Sequencer to slot store
  typedef struct packed {
    logic val_we;
    idx_t val_waddr;
    val_t val_wdata;
    idx_t val_raddr;
    logic nx_we0;
    idx_t nx_waddr0;
    idx_t nx_wdata0;
    logic nx_we1;
    idx_t nx_waddr1;
    idx_t nx_wdata1;
    idx_t nx_raddr;
    logic fr_we;
    idx_t fr_waddr;
    logic fr_wdata;
    idx_t fr_raddr;
  } store_cmd_t;

  // Slot store to sequencer
  typedef struct packed {
    val_t val_rdata;
    idx_t nx_rdata;
    idx_t head_next;
    logic fr_rdata;
  } store_stat_t;

  typedef struct packed {
    logic busy;
    cnt_t count;
  } ctrl_stat_t;

endpackage

`default_nettype wire

/* sv/ille_store.sv */
// Slot storage: value memory (registered read), next links and free marks.
// Depends on ille_pkg.
`default_nettype none

module ille_store import ille_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  store_cmd_t  cmd,
  output store_stat_t stat
);

  val_t                val_mem [NSLOTS];
  val_t                val_rdata;
  idx_t                nx [NSLOTS];
  logic [NSLOTS-1:0]   fr;

  // Value memory: no reset, read data registered.
  always_ff @(posedge clk) begin
    if (cmd.val_we) begin
      val_mem[cmd.val_waddr] <= cmd.val_wdata;
    end
    val_rdata <= val_mem[cmd.val_raddr];
  end

  // Links: reset to all zero, head points to itself.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSLOTS; i++) begin
        nx[i] <= '0;
      end
    end else begin
      if (cmd.nx_we0) begin
        nx[cmd.nx_waddr0] <= cmd.nx_wdata0;
      end
      if (cmd.nx_we1) begin
        nx[cmd.nx_waddr1] <= cmd.nx_wdata1;
      end
    end
  end

  // Free marks: every slot free except the sentinel.
  always_ff @(posedge clk) begin
    if (rst) begin
      fr <= {{CAPACITY{1'b1}}, 1'b0};
    end else if (cmd.fr_we) begin
      fr[cmd.fr_waddr] <= cmd.fr_wdata;
    end
  end

  assign stat.val_rdata = val_rdata;
  assign stat.nx_rdata  = nx[cmd.nx_raddr];
  assign stat.head_next = nx[0];
  assign stat.fr_rdata  = fr[cmd.fr_raddr];

endmodule

`default_nettype wire

/* sv/ille_ctrl.sv */
// Command sequencer: free-slot scan, list walk with the shared value
// comparator, link updates and result generation. Depends on ille_pkg.
`default_nettype none

module ille_ctrl import ille_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  in_t         cmd_item,
  output logic        cmd_stall,
  output logic        res_valid,
  output out_t        res_item,
  input  logic        res_ready,
  output store_cmd_t  scmd,
  input  store_stat_t sstat,
  output ctrl_stat_t  cstat
);

  state_e  state, state_next;
  cmd_e    cmd;
  val_t    nv;
  val_t    key;
  idx_t    cur;
  idx_t    prev;
  idx_t    slot;
  idx_t    at;
  idx_t    scan;
  cnt_t    steps;
  cnt_t    count;
  status_e resp_status;

  logic    accept;
  logic    hit;
  logic    walk_end;
  logic    show_last;
  logic    list_empty;
  cmd_e    in_cmd;

  assign in_cmd     = cmd_e'(cmd_item.command);
  assign accept     = cmd_valid && (state == S_IDLE);
  assign hit        = (sstat.val_rdata == key);
  assign walk_end   = (cur == '0) || (steps == cnt_t'(CAPACITY));
  assign show_last  = (sstat.nx_rdata == '0) || (steps == cnt_t'(CAPACITY - 1));
  assign list_empty = (count == '0) || (sstat.head_next == '0);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_SHOW:   state_next = list_empty ? S_RESP : S_SHOW_RD;
            CMD_DELETE: state_next = (count == '0) ? S_RESP : S_FIND_RD;
            default:    state_next = (count >= cnt_t'(CAPACITY)) ? S_RESP : S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        if (sstat.fr_rdata) begin
          state_next = (count == '0) ? S_LINK : S_FIND_RD;
        end else if (scan == idx_t'(CAPACITY)) begin
          state_next = S_RESP;
        end
      end
      S_FIND_RD:  state_next = walk_end ? S_RESP : S_FIND_CMP;
      S_FIND_CMP: begin
        if (hit) begin
          state_next = (cmd == CMD_DELETE) ? S_RESP : S_LINK;
        end else begin
          state_next = S_FIND_RD;
        end
      end
      S_LINK:     state_next = S_RESP;
      S_SHOW_RD:  state_next = S_SHOW_EMIT;
      S_SHOW_EMIT: begin
        if (res_ready) begin
          state_next = show_last ? S_IDLE : S_SHOW_RD;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs and store commands
  always_comb begin
    scmd           = '0;
    scmd.val_raddr = cur;
    scmd.nx_raddr  = (state == S_LINK) ? at : cur;
    scmd.fr_raddr  = scan;
    res_valid      = 1'b0;
    res_item       = '0;
    unique case (state)
      S_FIND_CMP: begin
        if (hit && (cmd == CMD_DELETE)) begin
          scmd.nx_we0    = 1'b1;
          scmd.nx_waddr0 = prev;
          scmd.nx_wdata0 = sstat.nx_rdata;
          scmd.nx_we1    = 1'b1;
          scmd.nx_waddr1 = cur;
          scmd.nx_wdata1 = '0;
          scmd.fr_we     = 1'b1;
          scmd.fr_waddr  = cur;
          scmd.fr_wdata  = 1'b1;
        end
      end
      S_LINK: begin
        scmd.val_we    = 1'b1;
        scmd.val_waddr = slot;
        scmd.val_wdata = nv;
        scmd.nx_we0    = 1'b1;
        scmd.nx_waddr0 = slot;
        scmd.nx_wdata0 = sstat.nx_rdata;
        scmd.nx_we1    = 1'b1;
        scmd.nx_waddr1 = at;
        scmd.nx_wdata1 = slot;
        scmd.fr_we     = 1'b1;
        scmd.fr_waddr  = slot;
        scmd.fr_wdata  = 1'b0;
      end
      S_SHOW_EMIT: begin
        res_valid          = 1'b1;
        res_item.out_value = sstat.val_rdata;
        res_item.status    = ST_OK;
        res_item.last      = show_last;
      end
      S_RESP: begin
        res_valid       = 1'b1;
        res_item.status = resp_status;
        res_item.last   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Element count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == S_LINK) begin
      count <= count + cnt_t'(1);
    end else if ((state == S_FIND_CMP) && hit && (cmd == CMD_DELETE)) begin
      count <= count - cnt_t'(1);
    end
  end

  // Walk and scan registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd   <= in_cmd;
          nv    <= cmd_item.new_value;
          key   <= (in_cmd == CMD_DELETE) ? cmd_item.new_value : cmd_item.anchor_value;
          cur   <= sstat.head_next;
          prev  <= '0;
          steps <= '0;
          scan  <= idx_t'(1);
          resp_status <= (in_cmd == CMD_SHOW || in_cmd == CMD_DELETE) ? ST_EMPTY : ST_FULL;
        end
      end
      S_SCAN: begin
        if (sstat.fr_rdata) begin
          slot <= scan;
          at   <= '0;
        end else begin
          scan <= scan + idx_t'(1);
        end
      end
      S_FIND_RD: begin
        if (walk_end) begin
          resp_status <= ST_MISSING;
        end
      end
      S_FIND_CMP: begin
        if (hit) begin
          at          <= (cmd == CMD_INS_AFTER) ? cur : prev;
          resp_status <= ST_OK;
        end else begin
          prev  <= cur;
          cur   <= sstat.nx_rdata;
          steps <= steps + cnt_t'(1);
        end
      end
      S_LINK: resp_status <= ST_OK;
      S_SHOW_EMIT: begin
        if (res_ready) begin
          cur   <= sstat.nx_rdata;
          steps <= steps + cnt_t'(1);
        end
      end
      default: ;
    endcase
  end

  assign cmd_stall   = (state != S_IDLE);
  assign cstat.busy  = (state != S_IDLE);
  assign cstat.count = count;

endmodule

`default_nettype wire

/* sv/index_linked_list_engine.sv */
// Index linked list engine, top level: sequencer, slot store, result register.
// Depends on ille_pkg, ille_store, ille_ctrl and the assertion macro header.
//
// Usage
//   cmd channel: cmd_valid / cmd_stall / cmd_item (command, new_value,
//   anchor_value). An item is taken when cmd_valid is high and cmd_stall low.
//   cmd_stall stays high from the accept until the command's last result
//   has been handed to the result register; one command is in work at a time.
//   res channel: res_valid / res_stall / res_item (out_value, status, last).
//   Show gives one item per element, last on the final one; every other
//   command, and show of an empty list, gives exactly one item with last set.
// Sequence
//   Walking a node passes S_FIND_RD (registered value-memory read), then
//   S_FIND_CMP (the shared compare). Insert: accept, free-slot scan, walk to
//   the anchor, link, response. Delete: accept, walk, response; a missing
//   value ends the walk in S_FIND_RD before the response.
//   Show: accept, then a value read and an emit per element.
// Reset (rst, synchronous): list empty, all slots free, result register empty.
// Stall: a stalled result holds in the output register; the sequencer waits
//   on it and keeps cmd_stall high until the result can be placed.
`default_nettype none
`include "index_linked_list_engine_defines.svh"

module index_linked_list_engine import ille_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  in_t  cmd_item,
  output logic res_valid,
  input  logic res_stall,
  output out_t res_item
);

  store_cmd_t  scmd;
  store_stat_t sstat;
  ctrl_stat_t  cstat;
  logic        res_valid_c;
  out_t        res_item_c;
  logic        res_ready;

  ille_store u_store (
    .clk  (clk),
    .rst  (rst),
    .cmd  (scmd),
    .stat (sstat)
  );

  ille_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_item  (cmd_item),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid_c),
    .res_item  (res_item_c),
    .res_ready (res_ready),
    .scmd      (scmd),
    .sstat     (sstat),
    .cstat     (cstat)
  );

  // Result register: refills whenever empty or being drained this cycle.
  assign res_ready = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_ready) begin
      res_valid <= res_valid_c;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid_c) begin
      res_item <= res_item_c;
    end
  end

  // Checks
  `ILLE_ASSERT(a_count_range, 1'b1, cstat.count <= cnt_t'(CAPACITY), "count above capacity")
  `ILLE_ASSERT_NXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall, "not busy after accept")
  `ILLE_ASSERT(a_result_when_busy, res_valid_c, cstat.busy, "result while idle")
  `ILLE_ASSERT_NXT(a_count_step, 1'b1, (cstat.count == $past(cstat.count)) || (cstat.count == $past(cstat.count) + cnt_t'(1)) || (cstat.count + cnt_t'(1) == $past(cstat.count)), "count jumped")

endmodule

`default_nettype wire

/* tb/index_linked_list_engine_tb.sv */
// Self-checking testbench for the index linked list engine.
// Needs ille_pkg and the engine RTL; holds its own list predictor in a scoreboard class.
// Directed list edits first, then random grow/shrink sequences with handshake idling.
module index_linked_list_engine_tb;
  import ille_pkg::*;

  // Predicts the engine's replies from a private copy of the slot arrays and
  // queues them until the block hands them out.
  class list_scoreboard;
    val_t   node_value[NSLOTS];
    idx_t   node_link[NSLOTS];
    bit     node_open[NSLOTS];
    int     node_total;
    out_t   pending[$];
    int     errors;
    int     commands;
    int     results;
    int     full_hits;
    int     empty_hits;
    int     missing_hits;
    int     longest;

    function new();
      for (int i = 0; i < NSLOTS; i++) begin
        node_value[i] = '0;
        node_link[i]  = '0;
        node_open[i]  = (i != 0);
      end
      node_total = 0;
    endfunction

    function void push_reply(val_t v, status_e st, bit fin);
      out_t r;
      r.out_value = v;
      r.status    = st;
      r.last      = fin;
      pending.push_back(r);
      case (st)
        ST_FULL:    full_hits++;
        ST_EMPTY:   empty_hits++;
        ST_MISSING: missing_hits++;
        default: ;
      endcase
    endfunction

    // Walk from the head; the sentinel itself is never compared.
    function bit find_prev(val_t v, output idx_t prev);
      idx_t cur;
      int   steps;
      prev  = '0;
      cur   = node_link[0];
      steps = 0;
      while (cur != 0 && steps < CAPACITY) begin
        if (node_value[cur] == v) return 1'b1;
        prev = cur;
        cur  = node_link[cur];
        steps++;
      end
      return 1'b0;
    endfunction

    function idx_t lowest_open();
      for (int i = 1; i < NSLOTS; i++)
        if (node_open[i]) return idx_t'(i);
      return '0;
    endfunction

    // Random value currently held in the list (list must be non-empty).
    function val_t some_member();
      idx_t cur;
      int   pick;
      cur  = node_link[0];
      pick = $urandom_range(0, node_total - 1);
      for (int k = 0; k < pick; k++) cur = node_link[cur];
      return node_value[cur];
    endfunction

    function void note_command(in_t it);
      idx_t cur, nx, prev, slot, at;
      int   n;
      commands++;
      case (it.command)
        CMD_SHOW: begin
          cur = node_link[0];
          if (node_total == 0 || cur == 0) begin
            push_reply('0, ST_EMPTY, 1'b1);
          end else begin
            n = 0;
            while (cur != 0 && n < CAPACITY) begin
              nx = node_link[cur];
              push_reply(node_value[cur], ST_OK, (nx == 0) || (n + 1 >= CAPACITY));
              n++;
              cur = nx;
            end
          end
        end
        CMD_DELETE: begin
          if (node_total == 0) begin
            push_reply('0, ST_EMPTY, 1'b1);
          end else if (!find_prev(it.new_value, prev)) begin
            push_reply('0, ST_MISSING, 1'b1);
          end else begin
            slot = node_link[prev];
            node_link[prev] = node_link[slot];
            node_link[slot] = '0;
            node_open[slot] = 1'b1;
            node_total--;
            push_reply('0, ST_OK, 1'b1);
          end
        end
        default: begin
          slot = lowest_open();
          if (node_total >= CAPACITY || slot == 0) begin
            push_reply('0, ST_FULL, 1'b1);
          end else if (node_total != 0 && !find_prev(it.anchor_value, prev)) begin
            push_reply('0, ST_MISSING, 1'b1);
          end else begin
            // empty list: anchor ignored, new node hangs off the head
            if (node_total == 0) at = '0;
            else at = (it.command == CMD_INS_AFTER) ? node_link[prev] : prev;
            node_value[slot] = it.new_value;
            node_link[slot]  = node_link[at];
            node_link[at]    = slot;
            node_open[slot]  = 1'b0;
            node_total++;
            if (node_total > longest) longest = node_total;
            push_reply('0, ST_OK, 1'b1);
          end
        end
      endcase
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $error("unexpected result item: out_value %0d status %0d last %0d",
               got.out_value, got.status, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      results++;
      if (got.out_value !== want.out_value) begin
        $error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  typedef enum int {MIX_FILL, MIX_GROW, MIX_SHRINK, MIX_NOISE} mix_e;

  localparam val_t VMIN = 32'h8000_0000;
  localparam val_t VMAX = 32'h7fff_ffff;
  localparam val_t VNEG = 32'hffff_ffff;
  localparam int   RANDOM_ITEMS = 350;
  localparam int   SETTLE = 80;
  localparam int   LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  in_t  cmd_item = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  out_t res_item;

  bit hold_request = 1'b0;   // sender asks for one long receiver hold-off
  bit calm = 1'b0;           // end of run: no idling on either side

  list_scoreboard sb;

  index_linked_list_engine dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: check every accepted item against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(res_item);
  end

  // Receiver stall pattern: random bursts, free stretches, one long hold.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        res_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        res_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Present one item and hold it until the block takes it.
  task automatic offer(input in_t it);
    cmd_item  <= it;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sb.note_command(it);
  endtask

  task automatic directed(input cmd_e c, input val_t nv, input val_t av);
    in_t it;
    it.command      = c;
    it.new_value    = nv;
    it.anchor_value = av;
    offer(it);
  endtask

  task automatic sender_gap(input int n);
    cmd_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Pause the sender until every predicted reply has arrived.
  task automatic settle_out();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mix of extremes, a small pool that forces duplicates, and full-range values.
  function automatic val_t pick_value();
    case ($urandom_range(0, 9))
      0: return VMIN;
      1: return VMAX;
      2: return VNEG;
      3, 4, 5: return val_t'($urandom_range(0, 7));
      default: return val_t'($urandom());
    endcase
  endfunction

  function automatic val_t pick_known();
    if (sb.node_total != 0 && $urandom_range(0, 9) < 8) return sb.some_member();
    return pick_value();
  endfunction

  function automatic in_t make_item(input mix_e mix);
    in_t it;
    int  r;
    r = $urandom_range(0, 99);
    it.new_value    = pick_value();
    it.anchor_value = pick_known();
    case (mix)
      MIX_FILL:   it.command = r < 50 ? CMD_INS_BEFORE : CMD_INS_AFTER;
      MIX_GROW:   it.command = r < 35 ? CMD_INS_BEFORE : r < 70 ? CMD_INS_AFTER :
                               r < 80 ? CMD_SHOW : CMD_DELETE;
      MIX_SHRINK: it.command = r < 70 ? CMD_DELETE : r < 85 ? CMD_SHOW :
                               r < 92 ? CMD_INS_BEFORE : CMD_INS_AFTER;
      default: begin
        it.command      = cmd_e'($urandom_range(0, 3));
        it.new_value    = val_t'($urandom());
        it.anchor_value = val_t'($urandom());
      end
    endcase
    // deletes mostly hit a stored value
    if (mix != MIX_NOISE && it.command == CMD_DELETE) it.new_value = pick_known();
    return it;
  endfunction

  initial begin
    mix_e mix;
    int   wait_cycles;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-list corners, head/tail/middle edits, duplicates, extremes.
    directed(CMD_SHOW,       '0,    '0);     // show on empty list
    directed(CMD_DELETE,     32'd5, '0);     // delete on empty list
    directed(CMD_INS_BEFORE, VMIN,  VMAX);   // empty: anchor ignored
    directed(CMD_INS_AFTER,  VMAX,  VMIN);
    directed(CMD_INS_BEFORE, VNEG,  VMAX);   // middle
    directed(CMD_INS_AFTER,  '0,    VMAX);   // after the tail
    directed(CMD_INS_BEFORE, 32'd7, VMIN);   // before the head
    directed(CMD_INS_AFTER,  32'd1, 32'd12345); // anchor not present
    directed(CMD_SHOW,       '0,    '0);
    directed(CMD_INS_AFTER,  VMAX,  VNEG);   // duplicate value
    directed(CMD_DELETE,     VMAX,  '0);     // removes first copy only
    directed(CMD_DELETE,     32'd99, '0);    // value not present
    directed(CMD_DELETE,     32'd7, '0);     // head
    directed(CMD_DELETE,     '0,    '0);     // tail
    directed(CMD_SHOW,       '0,    '0);
    directed(CMD_DELETE,     VMIN,  '0);
    directed(CMD_DELETE,     VNEG,  '0);
    directed(CMD_DELETE,     VMAX,  '0);     // list empty again
    directed(CMD_SHOW,       '0,    '0);
    directed(CMD_INS_AFTER,  VNEG,  VNEG);   // empty: anchor ignored
    directed(CMD_SHOW,       '0,    '0);
    settle_out();

    // Random: fill to capacity first, then alternate grow and shrink stretches.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < 20) mix = MIX_FILL;
      else if ($urandom_range(0, 9) == 0) mix = MIX_NOISE;
      else mix = ((i / 40) % 2) ? MIX_SHRINK : MIX_GROW;
      if (i == 100) hold_request = 1'b1;   // sender keeps offering meanwhile
      if (i == 200) settle_out();
      if (i == 280) calm = 1'b1;
      offer(make_item(mix));
      if (!calm && $urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 18));
    end
    cmd_valid <= 1'b0;

    // Drain, bounded.
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 50_000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d predicted result items never arrived", sb.pending.size());
      sb.errors++;
    end

    $display("Covered %0d commands and %0d result items; longest list %0d entries.",
             sb.commands, sb.results, sb.longest);
    $display("Replies seen: %0d full, %0d empty, %0d not found.",
             sb.full_hits, sb.empty_hits, sb.missing_hits);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/ille_pkg.sv
sv/ille_store.sv
sv/ille_ctrl.sv
sv/index_linked_list_engine.sv
tb/index_linked_list_engine_tb.sv
